@@ design/tlbla_pkg.sv @@
// shared types and constants for the tlb lookup/fill/aging block
// item structs, opcodes, controller/datapath command and status
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlbla_pkg;

    localparam int ADDR_W   = 32;
    localparam int FRAME_W  = 20;
    localparam int AGE_W    = 16;
    localparam int TOTAL_W  = 32;
    localparam int OPCODE_W = 2;

    // ages are scanned in groups of this many entries
    localparam int GRP_SIZE = 8;

    localparam int DEF_ENTRIES          = 16;
    localparam int DEF_PAGE_OFFSET_BITS = 12;

    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FILL   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_INVAL  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ADDR_W-1:0]   vaddr;
        logic [FRAME_W-1:0]  frame;
    } req_item_t;

    typedef struct packed {
        logic               hit;
        logic [ADDR_W-1:0]  paddr;
        logic [TOTAL_W-1:0] misses;
        logic [TOTAL_W-1:0] accesses;
    } rsp_item_t;

    typedef struct packed {
        logic load;
        logic cmp;
        logic sel;
        logic upd;
    } dp_cmd_t;

    typedef struct packed {
        logic need_sel;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ design/tlb_lookup_fill_aging.sv @@
// flow: an accepted item passes compare and update before its result is
// registered, plus select (oldest-entry scan) for a fill into a full table;
// a new item is taken in the update state of the previous one if the output
// is free; the compare/update sequence of the shared entry array sets the pace
// reset: valid bits, ages and both totals clear at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

// fully associative tlb top level, controller plus datapath
// depends on tlbla_pkg, tlbla_ctrl, tlbla_dp
module tlb_lookup_fill_aging
    import tlbla_pkg::*;
#(
    parameter int ENTRIES          = DEF_ENTRIES,
    parameter int PAGE_OFFSET_BITS = DEF_PAGE_OFFSET_BITS
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    // request item channel
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire req_item_t req,
    // response item channel
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output rsp_item_t      rsp
);

    // command and status between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: accepts an item when idle, or in the update state of the
    // previous one if the output is free; the response register decouples the
    // output side, so an item is taken from idle while a result waits
    tlbla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: compare cycle matches all tags in parallel, picks the first
    // free entry and reduces ages per group of eight; select cycle finishes
    // the oldest-entry search; update cycle writes ages, valids, tags, frame
    // store and the response register
    tlbla_dp #(
        .ENTRIES          (ENTRIES),
        .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

@@ design/tlbla_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tlbla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/tlbla_ctrl.sv @@
// sequencing state machine for the tlb: accept, compare, victim select, update
// depends on tlbla_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlbla_ctrl
    import tlbla_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SEL,
        S_UPD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;
    logic   req_acc;

    // output register can take a new result this cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == S_IDLE) || ((state_reg == S_UPD) && out_free));
    assign req_acc   = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd.load = req_acc;
        cmd.cmp  = (state_reg == S_CMP);
        cmd.sel  = (state_reg == S_SEL);
        cmd.upd  = (state_reg == S_UPD) && out_free;
    end

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = stat.need_sel ? S_SEL : S_UPD;
            end
            S_SEL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = req_acc ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_upd_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |=> rsp_valid_reg)
        else $error("update did not present a result");

    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.cmp, cmd.sel, cmd.upd}))
        else $error("more than one datapath phase active");

    a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) && !cmd.upd |=> (state_reg == S_UPD))
        else $error("left update while result register was blocked");

endmodule

`default_nettype wire

@@ design/tlbla_dp.sv @@
// tlb datapath: entry registers, tag compare, age scan, counters, result register
// depends on tlbla_pkg and tlbla_ram (frame store)
`timescale 1ns / 1ps
`default_nettype none

module tlbla_dp
    import tlbla_pkg::*;
#(
    parameter int ENTRIES          = DEF_ENTRIES,
    parameter int PAGE_OFFSET_BITS = DEF_PAGE_OFFSET_BITS
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire req_item_t req,
    input  wire dp_cmd_t   cmd,
    output dp_stat_t       stat,
    output rsp_item_t      rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int TAG_W = ADDR_W - PAGE_OFFSET_BITS;
    localparam int GRP_N = (ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD_N = GRP_N * GRP_SIZE;

    req_item_t          item_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [TAG_W-1:0]   tag_reg [ENTRIES];
    logic [AGE_W-1:0]   age_reg [ENTRIES];
    logic [TOTAL_W-1:0] miss_reg;
    logic [TOTAL_W-1:0] miss_next;
    logic [TOTAL_W-1:0] access_reg;
    logic [TOTAL_W-1:0] access_next;
    rsp_item_t          rsp_reg;
    rsp_item_t          rsp_next;

    logic [TAG_W-1:0]   tag_q;
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] match_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   victim_reg;

    logic [AGE_W-1:0]   age_pad     [PAD_N];
    logic [AGE_W-1:0]   grp_age     [GRP_N];
    logic [IDX_W-1:0]   grp_idx     [GRP_N];
    logic [AGE_W-1:0]   grp_age_reg [GRP_N];
    logic [IDX_W-1:0]   grp_idx_reg [GRP_N];
    logic [AGE_W-1:0]   oldest_age;
    logic [IDX_W-1:0]   oldest_idx;

    logic [FRAME_W-1:0]        ram_rdata;
    logic [ADDR_W+FRAME_W-1:0] frame_shift;
    logic                      is_lookup;
    logic                      is_fill;
    logic                      is_inval;

    assign tag_q     = item_reg.vaddr[ADDR_W-1:PAGE_OFFSET_BITS];
    assign is_lookup = (item_reg.opcode == OP_LOOKUP);
    assign is_fill   = (item_reg.opcode == OP_FILL);
    assign is_inval  = (item_reg.opcode == OP_INVAL);

    // full table on a fill needs the age scan
    assign stat.need_sel = is_fill && (&valid_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= req;
        end
    end

    // parallel tag compare, valid entries only
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (tag_reg[i] == tag_q);
        end
    end

    // lowest matching index and lowest free index
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // first pass of the age scan: best of each group, lowest index on ties
    genvar p;
    generate
        for (p = 0; p < PAD_N; p++)
        begin : g_pad
            if (p < ENTRIES)
            begin : g_real
                assign age_pad[p] = age_reg[p];
            end
            else
            begin : g_fill
                assign age_pad[p] = '0;
            end
        end
    endgenerate

    genvar g;
    generate
        for (g = 0; g < GRP_N; g++)
        begin : g_grp
            logic [AGE_W-1:0] best_age;
            logic [IDX_W-1:0] best_idx;

            always_comb
            begin
                best_age = age_pad[g*GRP_SIZE];
                best_idx = IDX_W'(g*GRP_SIZE);
                for (int k = 1; k < GRP_SIZE; k++)
                begin
                    if (age_pad[g*GRP_SIZE+k] > best_age)
                    begin
                        best_age = age_pad[g*GRP_SIZE+k];
                        best_idx = IDX_W'(g*GRP_SIZE+k);
                    end
                end
            end

            assign grp_age[g] = best_age;
            assign grp_idx[g] = best_idx;
        end
    endgenerate

    // second pass over the registered group winners
    always_comb
    begin
        oldest_age = grp_age_reg[0];
        oldest_idx = grp_idx_reg[0];
        for (int j = 1; j < GRP_N; j++)
        begin
            if (grp_age_reg[j] > oldest_age)
            begin
                oldest_age = grp_age_reg[j];
                oldest_idx = grp_idx_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmp)
        begin
            match_reg   <= match;
            hit_reg     <= |match;
            hit_idx_reg <= hit_idx;
            victim_reg  <= free_idx;
            for (int j = 0; j < GRP_N; j++)
            begin
                grp_age_reg[j] <= grp_age[j];
                grp_idx_reg[j] <= grp_idx[j];
            end
        end
        else if (cmd.sel)
        begin
            victim_reg <= oldest_idx;
        end
    end

    // frame store, read at the hit index during compare
    tlbla_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (ENTRIES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (cmd.upd && is_fill),
        .waddr (victim_reg),
        .wdata (item_reg.frame),
        .re    (cmd.cmp),
        .raddr (hit_idx),
        .rdata (ram_rdata)
    );

    // entry update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else if (cmd.upd)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                case (item_reg.opcode)
                    OP_LOOKUP:
                    begin
                        if (valid_reg[i])
                        begin
                            if (hit_reg && (hit_idx_reg == IDX_W'(i)))
                            begin
                                age_reg[i] <= '0;
                            end
                            else if (age_reg[i] != {AGE_W{1'b1}})
                            begin
                                age_reg[i] <= age_reg[i] + 1'b1;
                            end
                        end
                    end
                    OP_FILL:
                    begin
                        if (victim_reg == IDX_W'(i))
                        begin
                            valid_reg[i] <= 1'b1;
                            age_reg[i]   <= '0;
                        end
                    end
                    OP_INVAL:
                    begin
                        if (match_reg[i])
                        begin
                            valid_reg[i] <= 1'b0;
                            age_reg[i]   <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd && is_fill)
        begin
            tag_reg[victim_reg] <= tag_q;
        end
    end

    // saturating totals
    always_comb
    begin
        miss_next   = miss_reg;
        access_next = access_reg;
        if (cmd.upd && is_fill && (miss_reg != {TOTAL_W{1'b1}}))
        begin
            miss_next = miss_reg + 1'b1;
        end
        if (cmd.upd && is_lookup && (access_reg != {TOTAL_W{1'b1}}))
        begin
            access_next = access_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_reg   <= '0;
            access_reg <= '0;
        end
        else
        begin
            miss_reg   <= miss_next;
            access_reg <= access_next;
        end
    end

    // result: frame bits above the address width drop out
    assign frame_shift = {{ADDR_W{1'b0}}, ram_rdata} << PAGE_OFFSET_BITS;

    always_comb
    begin
        rsp_next.hit      = hit_reg && (is_lookup || is_inval);
        rsp_next.paddr    = '0;
        rsp_next.misses   = miss_next;
        rsp_next.accesses = access_next;
        if (is_lookup && hit_reg)
        begin
            rsp_next.paddr = frame_shift[ADDR_W-1:0]
                | {{TAG_W{1'b0}}, item_reg.vaddr[PAGE_OFFSET_BITS-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

    a_fill_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd && is_fill |=> valid_reg[$past(victim_reg)])
        else $error("fill did not validate its victim entry");

    a_hit_matches: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd && is_lookup && hit_reg |-> match_reg[hit_idx_reg])
        else $error("hit index does not point at a matching entry");

    a_totals_grow: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (access_reg >= $past(access_reg)) && (miss_reg >= $past(miss_reg)))
        else $error("a saturating total went backwards");

endmodule

`default_nettype wire
